// ===== sv/mbps_pkg.sv =====
package mbps_pkg;

    // window depth, in bytes
    localparam int MAX_PATTERN_BYTES = 16;
    // pattern bytes held in the two pattern registers
    localparam int PAT_BYTES = 16;
    localparam int PAT_IDX_W = $clog2(PAT_BYTES);

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 64;
    localparam int LEN_W  = 5;
    localparam int MASK_W = 16;
    localparam int CNT_W  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int SEL_W  = (CNT_W > PAT_IDX_W) ? CNT_W : PAT_IDX_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_ALL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 3'd5;

    // per-cell compare setup
    typedef struct packed {
        logic [BYTE_W-1:0] pat;
        logic              care;
    } t_cell_ctl;

    // pattern byte and care bit for one pattern position
    function automatic t_cell_ctl pat_sel(
        input logic [PAT_BYTES*BYTE_W-1:0] pattern,
        input logic [MASK_W-1:0]           mask,
        input logic [SEL_W-1:0]            pidx
    );
        t_cell_ctl              ctl;
        logic [PAT_IDX_W-1:0]   idx;
        idx = pidx[PAT_IDX_W-1:0];
        if (pidx < SEL_W'(PAT_BYTES)) begin
            ctl.pat  = pattern[idx*BYTE_W +: BYTE_W];
            ctl.care = mask[idx];
        end else begin
            ctl.pat  = '0;
            ctl.care = 1'b0;
        end
        return ctl;
    endfunction

endpackage

// ===== sv/mbps_in_if.sv =====
interface mbps_in_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/mbps_out_if.sv =====
interface mbps_out_if;
    import mbps_pkg::*;

    logic              valid;
    logic              ready;
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
    logic              region_end;

    modport source (output valid, output match_found, output match_address,
                    output region_end, input ready);
    modport sink   (input valid, input match_found, input match_address,
                    input region_end, output ready);
endinterface

// ===== sv/mbps_cell.sv =====
module mbps_cell
    import mbps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_clear,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cell_ctl         i_ctl,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_ok
);

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // the incoming byte is what this cell holds after the shift
    assign o_ok   = !i_ctl.care || (i_byte == i_ctl.pat);
    assign o_byte = r_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = '0;
        end else if (i_shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

endmodule

// ===== sv/masked_byte_pattern_scan.sv =====
// Masked byte pattern scanner: bytes of a region enter one item per cycle and
// shift through a row of sixteen cells, each holding one window byte and
// comparing the byte it is about to take against its pattern byte (or passing
// it as a wildcard). A match is reported when its final byte arrives, at
// base_address plus the offset of the match's first byte; in all-matches mode
// matches do not overlap, in first mode only the first one is reported. The
// byte flagged last_byte always yields a result with region_end set and then
// the window and offsets clear for the next region. Each result is registered
// in the output register, so a new item is taken every
// cycle while the result side keeps up; an output item that is not taken
// holds the input for as long. Configuration must be written only while idle; the block does not enforce it.
module masked_byte_pattern_scan
    import mbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mbps_in_if.sink               i_in,
    mbps_out_if.source            o_out
);

    // configuration registers
    logic [PAT_BYTES*BYTE_W-1:0] r_pattern;
    logic [MASK_W-1:0]           r_care;
    logic [LEN_W-1:0]            r_len;
    logic                        r_find_all;
    logic [ADDR_W-1:0]           r_base;

    // scan state
    logic [CNT_W-1:0]  r_since;
    logic [ADDR_W-1:0] r_offset;
    logic              r_first;

    // output register
    logic              r_out_valid;
    logic              r_out_found;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_end;

    logic              accept;
    logic [CNT_W-1:0]  len_eff;
    logic [CNT_W-1:0]  cnt_next;
    logic              all_ok;
    logic              hit;
    logic [ADDR_W-1:0] hit_addr;

    logic [BYTE_W-1:0] w_win [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] w_ok;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_care     <= '0;
            r_len      <= LEN_W'(1);
            r_find_all <= 1'b1;
            r_base     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PATTERN_LOW:    r_pattern[63:0]   <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern[127:64] <= i_cfg_data;
                CFG_CARE_MASK:      r_care     <= i_cfg_data[MASK_W-1:0];
                CFG_PATTERN_LENGTH: r_len      <= i_cfg_data[LEN_W-1:0];
                CFG_FIND_ALL:       r_find_all <= i_cfg_data[0];
                CFG_BASE_ADDRESS:   r_base     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake, no item taken while in reset
    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);

    // clamp the length to the window depth
    always_comb begin
        if (int'(r_len) > MAX_PATTERN_BYTES) begin
            len_eff = CNT_W'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = CNT_W'(r_len);
        end
    end

    assign cnt_next = (r_since == CNT_W'(MAX_PATTERN_BYTES)) ? r_since
                                                            : r_since + CNT_W'(1);

    // cell row: cell 0 takes the new byte, each other cell its neighbor's
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        localparam logic [SEL_W-1:0] CELL_K = SEL_W'(k);
        logic [BYTE_W-1:0] w_in_byte;
        logic [SEL_W-1:0]  w_pidx;
        t_cell_ctl         w_ctl;
        t_cell_ctl         w_sel;

        if (k == 0) begin : g_head
            assign w_in_byte = i_in.data_byte;
        end else begin : g_body
            assign w_in_byte = w_win[k-1];
        end

        // cell k holds pattern byte len-1-k when inside the pattern
        assign w_pidx = SEL_W'(len_eff) - SEL_W'(1) - CELL_K;
        assign w_sel  = pat_sel(r_pattern, r_care, w_pidx);
        always_comb begin
            w_ctl = w_sel;
            if (CELL_K >= SEL_W'(len_eff)) begin
                w_ctl.care = 1'b0;
            end
        end

        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_clear (accept && i_in.last_byte),
            .i_byte  (w_in_byte),
            .i_ctl   (w_ctl),
            .o_byte  (w_win[k]),
            .o_ok    (w_ok[k])
        );
    end

    // match decision
    assign all_ok = &w_ok;
    assign hit = (len_eff != '0) && (cnt_next >= len_eff) &&
                 !(!r_find_all && r_first) && all_ok;
    assign hit_addr = r_base + (r_offset + ADDR_W'(1) - ADDR_W'(len_eff));

    // scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since  <= '0;
            r_offset <= '0;
            r_first  <= 1'b0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_since  <= '0;
                r_offset <= '0;
                r_first  <= 1'b0;
            end else begin
                r_since  <= hit ? '0 : cnt_next;
                r_offset <= r_offset + ADDR_W'(1);
                if (hit && !r_find_all) begin
                    r_first <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && (hit || i_in.last_byte)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (hit || i_in.last_byte)) begin
            r_out_found <= hit;
            r_out_addr  <= hit ? hit_addr : '0;
            r_out_end   <= i_in.last_byte;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.match_found   = r_out_found;
    assign o_out.match_address = r_out_addr;
    assign o_out.region_end    = r_out_end;

    // checks
    a_since_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_since <= CNT_W'(MAX_PATTERN_BYTES))
        else $error("resume count above window depth");

    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_byte |=> r_out_valid && r_out_end && r_offset == '0
        && r_since == '0 && !r_first)
        else $error("region end not reported or state not cleared");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_found || r_out_end)
        else $error("result with neither match nor region end");

    a_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !r_find_all && r_first |-> !hit)
        else $error("second match reported in first mode");

endmodule
